// ===== design/led_grid_pattern_sequencer_assert.svh =====
// assertion macros for the led grid pattern sequencer
`ifndef LED_GRID_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_GRID_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LGPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lgps check failed");

// next-cycle implication, checked out of reset
`define LGPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lgps check failed");

`endif

// ===== design/lgps_pkg.sv =====
package lgps_pkg;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] pixel_index;
		logic [3:0]  slot;
		logic [5:0]  func_code;
		logic [15:0] pattern_param;
		logic [15:0] step_pause;
	} lgps_req_t;

	typedef struct packed {
		logic        lit;
		logic        write_enable;
		logic [11:0] target_address;
	} lgps_rsp_t;

	typedef struct packed {
		logic [5:0]  code;
		logic [15:0] param;
		logic [15:0] pause;
	} lgps_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_EVAL = 4'b1000
	} lgps_state_t;

	// signed width wide enough for step, pixel and parameter sums
	localparam int SW = 19;
	typedef logic signed [SW-1:0] lgps_sval_t;

	localparam int DIV_STEPS = 12;

	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	localparam logic [2:0] CFG_PATTERN_ROWS  = 3'd0;
	localparam logic [2:0] CFG_PATTERN_COLS  = 3'd1;
	localparam logic [2:0] CFG_GRID_ROWS     = 3'd2;
	localparam logic [2:0] CFG_GRID_COLS     = 3'd3;
	localparam logic [2:0] CFG_ROW_OFFSET    = 3'd4;
	localparam logic [2:0] CFG_COL_OFFSET    = 3'd5;
	localparam logic [2:0] CFG_PATTERN_COUNT = 3'd6;
	localparam logic [2:0] CFG_ON_ONLY       = 3'd7;

	localparam logic [5:0] FN_OFF        = 6'd0;
	localparam logic [5:0] FN_RUN_FWD    = 6'd1;
	localparam logic [5:0] FN_RUN_BACK   = 6'd2;
	localparam logic [5:0] FN_FILL_BACK  = 6'd3;
	localparam logic [5:0] FN_FILL_FWD   = 6'd4;
	localparam logic [5:0] FN_RUN_BOTH   = 6'd5;
	localparam logic [5:0] FN_CHECKER    = 6'd6;
	localparam logic [5:0] FN_CHECKER_RC = 6'd7;
	localparam logic [5:0] FN_COL_FWD    = 6'd10;
	localparam logic [5:0] FN_COL_BACK   = 6'd11;
	localparam logic [5:0] FN_ROW_FWD    = 6'd12;
	localparam logic [5:0] FN_ROW_BACK   = 6'd13;
	localparam logic [5:0] FN_BOX_IN     = 6'd14;
	localparam logic [5:0] FN_BOX_OUT    = 6'd15;
	localparam logic [5:0] FN_DIAGONAL   = 6'd16;
	localparam logic [5:0] FN_BAR_RISE   = 6'd31;
	localparam logic [5:0] FN_BAR_FALL   = 6'd32;
	localparam logic [5:0] FN_BAR_TOP    = 6'd33;
	localparam logic [5:0] FN_BAR_FROM   = 6'd34;

	function automatic logic [6:0] dim_clamp(logic [6:0] v, logic [6:0] maxv);
		logic [6:0] res;
		res = v;
		if (v == 7'd0) begin
			res = 7'd1;
		end else if (v > maxv) begin
			res = maxv;
		end
		return res;
	endfunction

endpackage

// ===== design/led_grid_pattern_sequencer.sv =====
// a pixel query, once accepted, runs 12 restoring divider steps by pattern_cols (one
// quotient bit per cycle), then the multiply and evaluate states; tick and load go
// straight to evaluate; the result is registered when evaluate ends, which waits
// while rsp is held; no new request is taken until the sequencer is back in idle
// reset: arst_n clears control state and step state and sets config registers to defaults;
// the pattern table is not cleared and holds garbage until loaded
module led_grid_pattern_sequencer #(
	parameter int MAX_DIM     = 64,
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  lgps_pkg::lgps_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lgps_pkg::lgps_rsp_t rsp
);
	import lgps_pkg::*;

	// table index width, at least one bit
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	// dimension clamp, never beyond what a 7 bit register can hold
	localparam logic [6:0] DIM_MAX = (MAX_DIM > 127) ? 7'd127 : 7'(MAX_DIM);
	localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

	// configuration registers
	logic [6:0]        rows_q, cols_q, grows_q, gcols_q;
	logic signed [7:0] roff_q, coff_q;
	logic [4:0]        count_q;
	logic              on_only_q;

	// step state
	logic [15:0]   timer_q, step_q;
	logic [IW-1:0] pidx_q;

	// pattern table, no reset
	lgps_entry_t table_q [TABLE_DEPTH];
	lgps_entry_t cur;

	// sequencer and datapath registers
	lgps_state_t state_q;
	logic [1:0]  op_q;
	logic [11:0] n_q;
	logic [11:0] quo_q;  // shifts the dividend out and the quotient in
	logic [6:0]  rem_q;
	logic [3:0]  dcnt_q;
	logic [23:0] st_q;   // step times target row
	logic [18:0] rc_q;   // row times cols
	logic [11:0] addr_q;
	logic        inside_q;
	lgps_rsp_t   rsp_q;
	logic        rsp_valid_q;

	logic [6:0]  dim_r, dim_c, dim_gr, dim_gc;
	logic [13:0] area;
	logic        acc;

	assign dim_r  = dim_clamp(rows_q, DIM_MAX);
	assign dim_c  = dim_clamp(cols_q, DIM_MAX);
	assign dim_gr = dim_clamp(grows_q, DIM_MAX);
	assign dim_gc = dim_clamp(gcols_q, DIM_MAX);
	assign area   = dim_r * dim_c;

	assign cur       = table_q[pidx_q];
	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// config write port, one register per enabled edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= 7'd8;
			cols_q    <= 7'd8;
			grows_q   <= 7'd8;
			gcols_q   <= 7'd8;
			roff_q    <= '0;
			coff_q    <= '0;
			count_q   <= 5'd1;
			on_only_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATTERN_ROWS:  rows_q    <= cfg_wdata[6:0];
				CFG_PATTERN_COLS:  cols_q    <= cfg_wdata[6:0];
				CFG_GRID_ROWS:     grows_q   <= cfg_wdata[6:0];
				CFG_GRID_COLS:     gcols_q   <= cfg_wdata[6:0];
				CFG_ROW_OFFSET:    roff_q    <= cfg_wdata;
				CFG_COL_OFFSET:    coff_q    <= cfg_wdata;
				CFG_PATTERN_COUNT: count_q   <= cfg_wdata[4:0];
				CFG_ON_ONLY:       on_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// table load, ignored for slots past the table
	logic [IW-1:0] slot_idx;
	assign slot_idx = IW'(req.slot);

	always_ff @(posedge clk) begin
		if (acc && req.op == OP_LOAD && 9'(req.slot) < DEPTH_LIM) begin
			table_q[slot_idx] <= '{code: req.func_code, param: req.pattern_param,
				pause: req.step_pause};
		end
	end

	// tick: timer, then step, then pattern, each wrapping
	logic [15:0] pause_eff;
	logic [16:0] step_len;
	logic [8:0]  cnt_eff;
	logic        timer_wrap, step_wrap, pidx_wrap;

	always_comb begin
		pause_eff = (cur.pause == 16'd0) ? 16'd1 : cur.pause;
		case (cur.code) inside
			[FN_RUN_FWD:FN_RUN_BOTH]:        step_len = 17'(area);
			FN_CHECKER, FN_CHECKER_RC:       step_len = 17'(cur.param);
			FN_COL_FWD, FN_COL_BACK, FN_BAR_RISE: step_len = 17'(dim_c);
			FN_ROW_FWD, FN_ROW_BACK:         step_len = 17'(dim_r);
			FN_BOX_IN, FN_BOX_OUT:           step_len = 17'(dim_c >> 1);
			FN_DIAGONAL:                     step_len = 17'(dim_r) + 17'(dim_c);
			[FN_BAR_FALL:FN_BAR_FROM]:       step_len = 17'(cur.param[15:8]);
			default:                         step_len = 17'd1;
		endcase
		if (count_q == 5'd0) begin
			cnt_eff = 9'd1;
		end else if (9'(count_q) > DEPTH_LIM) begin
			cnt_eff = DEPTH_LIM;
		end else begin
			cnt_eff = 9'(count_q);
		end
		timer_wrap = (17'(timer_q) + 17'd1) >= 17'(pause_eff);
		step_wrap  = (17'(step_q) + 17'd1) >= step_len;
		pidx_wrap  = (9'(pidx_q) + 9'd1) >= cnt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			step_q  <= '0;
			pidx_q  <= '0;
		end else if (acc && req.op == OP_TICK) begin
			if (timer_wrap) begin
				timer_q <= '0;
				if (step_wrap) begin
					step_q <= '0;
					pidx_q <= pidx_wrap ? '0 : pidx_q + IW'(1);
				end else begin
					step_q <= step_q + 16'd1;
				end
			end else begin
				timer_q <= timer_q + 16'd1;
			end
		end
	end

	// restoring divider step: pixel_index by pattern_cols
	logic [7:0] rem_sh;
	logic       rem_ge;
	assign rem_sh = {rem_q, quo_q[11]};
	assign rem_ge = rem_sh >= {1'b0, dim_c};

	// placement in the destination grid, from row and column
	logic signed [13:0] rr;
	logic signed [8:0]  cc;
	logic               inside_w;
	assign rr = $signed({2'b00, quo_q}) + 14'(roff_q);
	assign cc = $signed({2'b00, rem_q}) + 9'(coff_q);
	assign inside_w = (quo_q < 12'(dim_r)) && (rr >= 14'sd0) && (rr < $signed(14'(dim_gr)))
		&& (cc >= 9'sd0) && (cc < $signed(9'(dim_gc)));

	// pixel function of the current entry
	logic lit_w;
	always_comb begin
		lgps_sval_t ns, ss, ps, rs, cs, rd, cd, ts, lm1, hi, lo, rhi, rlo;
		logic       mb, a, b;
		logic [25:0] fill_lhs;
		ns  = lgps_sval_t'(n_q);
		ss  = lgps_sval_t'(step_q);
		ps  = lgps_sval_t'(cur.param);
		rs  = lgps_sval_t'(quo_q);
		cs  = lgps_sval_t'(rem_q);
		rd  = lgps_sval_t'(dim_r);
		cd  = lgps_sval_t'(dim_c);
		ts  = lgps_sval_t'(cur.param[15:8]);
		lm1 = lgps_sval_t'(area) - 19'sd1;
		mb  = (rem_q < 7'd8) && cur.param[rem_q[2:0]];
		a   = (ns >= ss) && (ns < ss + ps);
		b   = (ns <= lm1 - ss) && (ns + ps > lm1 - ss);
		hi  = '0;
		lo  = '0;
		rhi = '0;
		rlo = '0;
		// rounded fill row compare without a divide: r <= (2st+C)/(2C)
		fill_lhs = {1'b0, st_q, 1'b0} + 26'(dim_c);
		lit_w = 1'b0;
		case (cur.code)
			FN_RUN_FWD:    lit_w = a;
			FN_RUN_BACK:   lit_w = b;
			FN_FILL_BACK:  lit_w = ns >= lm1 - ss;
			FN_FILL_FWD:   lit_w = ns <= ss;
			FN_RUN_BOTH:   lit_w = a || b;
			FN_CHECKER:    lit_w = n_q[0] ^ step_q[0];
			FN_CHECKER_RC: lit_w = n_q[0] ^ quo_q[0] ^ step_q[0];
			FN_COL_FWD:    lit_w = ss == cs;
			FN_COL_BACK:   lit_w = ss == cd - 19'sd1 - cs;
			FN_ROW_FWD:    lit_w = ss == rs;
			FN_ROW_BACK:   lit_w = ss == rd - 19'sd1 - rs;
			FN_BOX_IN: begin
				hi  = cd - 19'sd1 - ss;
				rhi = rd - 19'sd1 - ss;
				lit_w = ((rs == ss || rs == rhi) && cs >= ss && cs <= hi)
					|| ((cs == ss || cs == hi) && rs >= ss && rs <= rhi);
			end
			FN_BOX_OUT: begin
				hi  = (cd >>> 1) + ss;
				lo  = cd - 19'sd1 - hi;
				rhi = (rd >>> 1) + ss;
				rlo = rd - 19'sd1 - rhi;
				lit_w = ((rs == rlo || rs == rhi) && cs >= lo && cs <= hi)
					|| ((cs == lo || cs == hi) && rs >= rlo && rs <= rhi);
			end
			FN_DIAGONAL: begin
				case (cur.param)
					16'd0:   lit_w = (ss >= rs) && (cs == ss - rs);
					16'd1:   lit_w = cs == cd - 19'sd1 - ss + rd - 19'sd1 - rs;
					16'd2:   lit_w = cs == cd - 19'sd1 - ss + rs;
					16'd3:   lit_w = cs == ss + rs - rd - 19'sd1;
					default: lit_w = 1'b0;
				endcase
			end
			FN_BAR_RISE: lit_w = mb && (fill_lhs >= {6'd0, rc_q, 1'b0});
			FN_BAR_FALL: lit_w = mb && (rs <= ts - ss - 19'sd1);
			FN_BAR_TOP:  lit_w = mb && (rs >= rd - ss - 19'sd1);
			FN_BAR_FROM: lit_w = mb && (rs >= ts + ss);
			default:     lit_w = 1'b0;
		endcase
	end

	// result of the item in evaluation; non-query requests give all zeros
	lgps_rsp_t rsp_w;
	always_comb begin
		rsp_w = '0;
		if (op_q == OP_QUERY) begin
			rsp_w.lit = lit_w;
			if (inside_q) begin
				rsp_w.write_enable   = lit_w || !on_only_q;
				rsp_w.target_address = addr_q;
			end
		end
	end

	logic rsp_free;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// sequencer: idle -> divide -> multiply -> evaluate for a query, idle -> evaluate otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (state_q == ST_EVAL && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						dcnt_q  <= '0;
						state_q <= (req.op == OP_QUERY) ? ST_DIV : ST_EVAL;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= req.op;
			n_q   <= req.pixel_index;
			quo_q <= req.pixel_index;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			quo_q <= {quo_q[10:0], rem_ge};
			rem_q <= rem_ge ? 7'(rem_sh - {1'b0, dim_c}) : rem_sh[6:0];
		end
		if (state_q == ST_MUL) begin
			st_q     <= step_q * cur.param[15:8];
			rc_q     <= quo_q * dim_c;
			addr_q   <= 12'(rr[6:0] * dim_gc + 14'(cc[6:0]));
			inside_q <= inside_w;
		end
		if (state_q == ST_EVAL && rsp_free) begin
			rsp_q <= rsp_w;
		end
	end

	`include "led_grid_pattern_sequencer_assert.svh"

	// a taken request always moves the sequencer out of idle in the next cycle
	`LGPS_ASSERT_NEXT(a_busy_after_accept, acc, !req_ready)
	// the divider hands over to the multiply cycle only after its last step
	`LGPS_ASSERT_NEXT(a_div_to_mul, state_q == ST_DIV && dcnt_q != 4'(DIV_STEPS - 1), state_q == ST_DIV)
	// in on-only mode an unlit pixel is never written
	`LGPS_ASSERT_NOW(a_on_only, rsp_valid_q && on_only_q && rsp_q.write_enable, rsp_q.lit)

endmodule
